[sv/mip_chain_box_downsampler_defines.svh]
// Assertion macros shared by the mip chain downsampler RTL.
`ifndef MIP_CHAIN_BOX_DOWNSAMPLER_DEFINES_SVH
`define MIP_CHAIN_BOX_DOWNSAMPLER_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define MCBD_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define MCBD_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mcbd_pkg.sv]
// Shared types, constants and arithmetic helpers of the mip chain downsampler.
package mcbd_pkg;

  localparam int TILE_SIZE  = 32;
  localparam int MIP_LEVELS = 6;

  function automatic int lvl_size(int l);
    return TILE_SIZE >> l;
  endfunction

  // A level makes children only if it is above the last level and at least 2 wide.
  function automatic logic can_step(int l);
    return (l <= MIP_LEVELS - 2) && (lvl_size(l) >= 2);
  endfunction

  // First slot of a lower level in the shared row store of the back end.
  function automatic int slot_base(int l);
    int s;
    s = 0;
    for (int k = 1; k < MIP_LEVELS; k++) begin
      if (k < l) s = s + lvl_size(k) / 2;
    end
    return s;
  endfunction

  function automatic int back_slots();
    int s;
    s = 0;
    for (int k = 1; k <= MIP_LEVELS - 2; k++) begin
      if (lvl_size(k) >= 2) s = s + lvl_size(k) / 2;
    end
    return s;
  endfunction

  localparam int CW         = $clog2(TILE_SIZE);
  localparam int LVLW       = $clog2(MIP_LEVELS);
  localparam int HALF0      = TILE_SIZE / 2;
  localparam int FAW        = (HALF0 > 1) ? $clog2(HALF0) : 1;
  localparam int BACK_DEPTH = (back_slots() > 1) ? back_slots() : 1;
  localparam int BAW        = (BACK_DEPTH > 1) ? $clog2(BACK_DEPTH) : 1;
  localparam int QDEPTH     = 8;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);

  localparam int OUT_LVL_W  = 3;
  localparam int OUT_XY_W   = 4;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [8:0] alpha;
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] red;
  } sum_t;

  typedef logic [CW-1:0]   coord_t;
  typedef logic [LVLW-1:0] lvl_t;

  // Level-1 pixel handed from the front end to the back end.
  typedef struct packed {
    pix_t   pix;
    coord_t y;
    coord_t x;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic                 last;
    pix_t                 pix;
    logic [OUT_XY_W-1:0]  y;
    logic [OUT_XY_W-1:0]  x;
    logic [OUT_LVL_W-1:0] lvl;
  } oitem_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EVAL,
    B_COMB
  } bstate_t;

  function automatic sum_t pair_sum(pix_t a, pix_t b);
    sum_t s;
    s.red   = {1'b0, a.red}   + {1'b0, b.red};
    s.green = {1'b0, a.green} + {1'b0, b.green};
    s.blue  = {1'b0, a.blue}  + {1'b0, b.blue};
    s.alpha = {1'b0, a.alpha} + {1'b0, b.alpha};
    return s;
  endfunction

  function automatic logic [7:0] mean4(logic [8:0] a, logic [8:0] b);
    logic [9:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[9:2];
  endfunction

  function automatic pix_t box_mean(sum_t top, sum_t bot);
    pix_t p;
    p.red   = mean4(top.red, bot.red);
    p.green = mean4(top.green, bot.green);
    p.blue  = mean4(top.blue, bot.blue);
    p.alpha = mean4(top.alpha, bot.alpha);
    return p;
  endfunction

endpackage

[sv/mcbd_front.sv]
// Front end: level-0 raster tracking, pair sums, row store and level-1 block output.
`include "mip_chain_box_downsampler_defines.svh"

module mcbd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcbd_pkg::pix_t     in_pix,
  output logic               q_push,
  output mcbd_pkg::qitem_t   q_item,
  input  mcbd_pkg::q_status_t q_stat
);

  localparam int CW = mcbd_pkg::CW;

  mcbd_pkg::coord_t fx_r, fy_r;
  mcbd_pkg::pix_t   fpend_r;
  mcbd_pkg::sum_t   fmem [mcbd_pkg::HALF0];
  logic             b_valid_r, b_valid_nxt;
  mcbd_pkg::sum_t   b_rd_r, b_pair_r;
  mcbd_pkg::coord_t b_x_r, b_y_r;

  logic                   accept, x_last, y_last, in_block;
  logic                   do_pend, do_top, do_comb;
  logic [CW:0]            blk_lim;
  logic [mcbd_pkg::FAW-1:0] widx;
  mcbd_pkg::sum_t         pair;

  assign in_ready = !b_valid_r || !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    x_last   = (fx_r == CW'(mcbd_pkg::lvl_size(0) - 1));
    y_last   = (fy_r == CW'(mcbd_pkg::lvl_size(0) - 1));
    blk_lim  = (CW+1)'(2 * (mcbd_pkg::lvl_size(0) / 2));
    in_block = ({1'b0, fx_r} < blk_lim) && ({1'b0, fy_r} < blk_lim);
    pair     = mcbd_pkg::pair_sum(fpend_r, in_pix);
    widx     = mcbd_pkg::FAW'(fx_r >> 1);
    do_pend  = accept && in_block && !fx_r[0];
    do_top   = accept && in_block && fx_r[0] && !fy_r[0];
    do_comb  = accept && in_block && fx_r[0] && fy_r[0];
    q_push   = b_valid_r && !q_stat.full;
    b_valid_nxt = (b_valid_r && q_stat.full) || do_comb;
    q_item.pix = mcbd_pkg::box_mean(b_rd_r, b_pair_r);
    q_item.x   = b_x_r;
    q_item.y   = b_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r      <= '0;
      fy_r      <= '0;
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (accept) begin
        if (x_last) begin
          fx_r <= '0;
          fy_r <= y_last ? '0 : CW'(fy_r + 1'b1);
        end else begin
          fx_r <= CW'(fx_r + 1'b1);
        end
      end
    end
  end

  // Even-row pair store; read back on the odd row below.
  always_ff @(posedge clk) begin
    if (do_top) fmem[widx] <= pair;
    if (do_comb) b_rd_r <= fmem[widx];
  end

  always_ff @(posedge clk) begin
    if (do_pend) fpend_r <= in_pix;
    if (do_comb) begin
      b_pair_r <= pair;
      b_x_r    <= fx_r >> 1;
      b_y_r    <= fy_r >> 1;
    end
  end

  `MCBD_ALWAYS(a_front_blk_x, !b_valid_r || (b_x_r < CW'(mcbd_pkg::HALF0)), "front block column out of range")
  `MCBD_ALWAYS(a_front_no_accept_full, !(accept && b_valid_r && q_stat.full), "front accepted while stalled")

endmodule

[sv/mcbd_queue.sv]
// Short queue of level-1 pixels between the front end and the back end.
`include "mip_chain_box_downsampler_defines.svh"

module mcbd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mcbd_pkg::qitem_t    push_item,
  input  logic                pop,
  output mcbd_pkg::qitem_t    pop_item,
  output mcbd_pkg::q_status_t stat
);

  localparam int QAW = mcbd_pkg::QAW;
  localparam int QCW = mcbd_pkg::QCW;

  mcbd_pkg::qitem_t mem_r [mcbd_pkg::QDEPTH];
  logic [QAW-1:0]   wr_r, rd_r;
  logic [QCW-1:0]   cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == QCW'(mcbd_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == QAW'(mcbd_pkg::QDEPTH - 1)) ? '0 : QAW'(wr_r + 1'b1);
      if (do_pop)  rd_r <= (rd_r == QAW'(mcbd_pkg::QDEPTH - 1)) ? '0 : QAW'(rd_r + 1'b1);
      if (do_push && !do_pop)      cnt_r <= QCW'(cnt_r + 1'b1);
      else if (do_pop && !do_push) cnt_r <= QCW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_item;
  end

  `MCBD_ALWAYS(a_queue_cnt, cnt_r <= QCW'(mcbd_pkg::QDEPTH), "queue count above depth")

endmodule

[sv/mcbd_back.sv]
// Back end: walks each level-1 pixel down the lower levels and buffers results.
`include "mip_chain_box_downsampler_defines.svh"

module mcbd_back (
  input  logic                clk,
  input  logic                rst_n,
  output logic                q_pop,
  input  mcbd_pkg::qitem_t    q_item,
  input  mcbd_pkg::q_status_t q_stat,
  output logic                out_valid,
  input  logic                out_ready,
  output mcbd_pkg::oitem_t    out_item
);

  localparam int CW   = mcbd_pkg::CW;
  localparam int LVLW = mcbd_pkg::LVLW;
  localparam int BAW  = mcbd_pkg::BAW;

  mcbd_pkg::bstate_t st_r, st_nxt;
  mcbd_pkg::lvl_t    res_lvl_r;
  mcbd_pkg::coord_t  res_x_r, res_y_r;
  mcbd_pkg::pix_t    res_pix_r;
  mcbd_pkg::coord_t  bx_r [mcbd_pkg::MIP_LEVELS];
  mcbd_pkg::coord_t  by_r [mcbd_pkg::MIP_LEVELS];
  mcbd_pkg::pix_t    bpend_r [mcbd_pkg::MIP_LEVELS];
  mcbd_pkg::sum_t    bmem [mcbd_pkg::BACK_DEPTH];
  mcbd_pkg::sum_t    rd_r, pair_r;
  mcbd_pkg::oitem_t  ofifo_r [2];
  logic              owr_r, ord_r;
  logic [1:0]        ocnt_r;

  logic             step_ok, x_last, y_last, in_block, o_full;
  logic             eval_go, step, k_pend, k_top, k_comb, emit, load, o_pop;
  logic [CW:0]      blk_lim;
  logic [BAW-1:0]   addr;
  mcbd_pkg::coord_t cx, cy;
  mcbd_pkg::sum_t   pair;
  mcbd_pkg::oitem_t o_new;

  always_comb begin
    step_ok  = mcbd_pkg::can_step(int'(res_lvl_r));
    cx       = bx_r[res_lvl_r];
    cy       = by_r[res_lvl_r];
    x_last   = (cx == CW'(mcbd_pkg::lvl_size(int'(res_lvl_r)) - 1));
    y_last   = (cy == CW'(mcbd_pkg::lvl_size(int'(res_lvl_r)) - 1));
    blk_lim  = (CW+1)'(2 * (mcbd_pkg::lvl_size(int'(res_lvl_r)) / 2));
    in_block = ({1'b0, cx} < blk_lim) && ({1'b0, cy} < blk_lim);
    pair     = mcbd_pkg::pair_sum(bpend_r[res_lvl_r], res_pix_r);
    addr     = BAW'(mcbd_pkg::slot_base(int'(res_lvl_r)) + int'(cx >> 1));
    o_full   = (ocnt_r == 2'd2);
    eval_go  = (st_r == mcbd_pkg::B_EVAL) && !o_full;
    step     = eval_go && step_ok;
    k_pend   = step && in_block && !cx[0];
    k_top    = step && in_block && cx[0] && !cy[0];
    k_comb   = step && in_block && cx[0] && cy[0];
    emit     = eval_go;

    o_new.lvl  = mcbd_pkg::OUT_LVL_W'(res_lvl_r);
    o_new.x    = mcbd_pkg::OUT_XY_W'(res_x_r);
    o_new.y    = mcbd_pkg::OUT_XY_W'(res_y_r);
    o_new.pix  = res_pix_r;
    o_new.last = !k_comb;

    out_valid = (ocnt_r != 2'd0);
    out_item  = ofifo_r[ord_r];
    o_pop     = out_valid && out_ready;
  end

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    load   = 1'b0;
    unique case (st_r)
      mcbd_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop  = 1'b1;
          load   = 1'b1;
          st_nxt = mcbd_pkg::B_EVAL;
        end
      end
      mcbd_pkg::B_EVAL: begin
        if (eval_go) begin
          if (k_comb) begin
            st_nxt = mcbd_pkg::B_COMB;
          end else if (!q_stat.empty) begin
            q_pop = 1'b1;
            load  = 1'b1;
          end else begin
            st_nxt = mcbd_pkg::B_IDLE;
          end
        end
      end
      mcbd_pkg::B_COMB: begin
        st_nxt = mcbd_pkg::B_EVAL;
      end
      default: begin
        st_nxt = mcbd_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= mcbd_pkg::B_IDLE;
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
      for (int l = 0; l < mcbd_pkg::MIP_LEVELS; l++) begin
        bx_r[l] <= '0;
        by_r[l] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (step) begin
        if (x_last) begin
          bx_r[res_lvl_r] <= '0;
          by_r[res_lvl_r] <= y_last ? '0 : CW'(cy + 1'b1);
        end else begin
          bx_r[res_lvl_r] <= CW'(cx + 1'b1);
        end
      end
      if (emit)  owr_r <= ~owr_r;
      if (o_pop) ord_r <= ~ord_r;
      if (emit && !o_pop)      ocnt_r <= ocnt_r + 2'd1;
      else if (o_pop && !emit) ocnt_r <= ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (k_top)  bmem[addr] <= pair;
    if (k_comb) rd_r <= bmem[addr];
  end

  always_ff @(posedge clk) begin
    if (k_pend) bpend_r[res_lvl_r] <= res_pix_r;
    if (emit) ofifo_r[owr_r] <= o_new;
    if (load) begin
      res_lvl_r <= LVLW'(1);
      res_x_r   <= q_item.x;
      res_y_r   <= q_item.y;
      res_pix_r <= q_item.pix;
    end
    if (k_comb) begin
      res_lvl_r <= LVLW'(res_lvl_r + 1'b1);
      res_x_r   <= cx >> 1;
      res_y_r   <= cy >> 1;
      pair_r    <= pair;
    end
    if (st_r == mcbd_pkg::B_COMB) res_pix_r <= mcbd_pkg::box_mean(rd_r, pair_r);
  end

  `MCBD_ALWAYS(a_back_ocnt, ocnt_r <= 2'd2, "result buffer overfilled")
  `MCBD_NEXT(a_back_comb, emit && !o_new.last, st_r == mcbd_pkg::B_COMB, "missing combine cycle")

endmodule

[sv/mip_chain_box_downsampler.sv]
// Top level of the streaming 2x2 box-filter mip chain builder.
//
//  channel | dir | ports                           | request
//  --------+-----+---------------------------------+--------------------------------------
//  in      | in  | in_tvalid in_tready in_tdata    | one level-0 RGBA8 pixel, raster order
//  out     | out | out_tvalid out_tready out_tdata | one lower-level pixel with level, x, y
//          |     | out_tlast                       |   tlast on final result of an input
//
// Flow: the front end takes one pixel per cycle while in_tready is high; a completed
//   level-1 block is registered in the front end and pushed once the queue has room.
//   The back end evaluates each queued pixel, and for each deeper-level pixel it
//   produces it reads the row store, then forms the mean.
// Reset: synchronous, active low; clears positions and queue/buffer pointers.
//   The row stores need no clearing pass: every entry is written before it is read.
// Stalls: a full queue holds in_tready low once a level-1 block waits; a full
//   result buffer holds the back end. The result buffer keeps two requests.
`include "mip_chain_box_downsampler_defines.svh"

module mip_chain_box_downsampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_level[2:0], out_x[6:3], out_y[10:7], out_red[18:11],
                                  // out_green[26:19], out_blue[34:27], out_alpha[42:35], zero
  output logic        out_tlast   // last_of_run
);

  mcbd_pkg::pix_t      in_pix;
  logic                q_push, q_pop;
  mcbd_pkg::qitem_t    q_in, q_out;
  mcbd_pkg::q_status_t q_stat;
  mcbd_pkg::oitem_t    o_item;

  assign in_pix = mcbd_pkg::pix_t'(in_tdata);

  // Classify level-0 pixels and emit completed level-1 blocks.
  mcbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pix   (in_pix),
    .q_push   (q_push),
    .q_item   (q_in),
    .q_stat   (q_stat)
  );

  // Decouple the front and back ends.
  mcbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .stat      (q_stat)
  );

  // Walk each level-1 pixel down the chain and buffer the results.
  mcbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop     (q_pop),
    .q_item    (q_out),
    .q_stat    (q_stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (o_item)
  );

  // Pack fields from the lowest bit up; pad to whole bytes.
  assign out_tdata = {5'b0, o_item.pix.alpha, o_item.pix.blue, o_item.pix.green,
                      o_item.pix.red, o_item.y, o_item.x, o_item.lvl};
  assign out_tlast = o_item.last;

endmodule
